@@ hw/rtl/tcw_pkg.sv @@
package tcw_pkg;

    // opcodes of an input beat
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // control bytes and fixed cell values
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] RESET_COLOR  = 8'h1F;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic [10:0] cursor_position;
        logic [7:0]  cell_char;
        logic [7:0]  cell_color;
    } out_item_t;

    // one screen cell, attribute in the upper byte
    typedef struct packed {
        logic [7:0] color;
        logic [7:0] ch;
    } cell_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic exec;
        logic sweep_step;
        logic load_result;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_sweep;
        logic sweep_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ hw/rtl/tcw_ctrl.sv @@
module tcw_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tcw_pkg::dp_status_t status,
    output tcw_pkg::dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_EXEC   = 5'b00100,
        ST_SWEEP  = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        in_ready        = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.need_sweep)
                begin
                    state_next = ST_SWEEP;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // state register, reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/tcw_datapath.sv @@
module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tcw_pkg::dp_cmd_t    cmd,
    output tcw_pkg::dp_status_t status,
    input  tcw_pkg::in_item_t   in_data,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                out_ready,
    output logic                out_valid,
    output tcw_pkg::out_item_t  out_data
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

    // screen store
    tcw_pkg::cell_t mem [CELLS];

    logic [7:0]          text_color_reg;
    tcw_pkg::in_item_t   item_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ADDR_W-1:0]   lin_reg;
    logic [ADDR_W-1:0]   lin_next;
    logic [ADDR_W-1:0]   sweep_cnt_reg;
    logic                sweep_copy_reg;
    logic [7:0]          sweep_color_reg;
    logic                pend_valid_reg;
    logic                pend_copy_reg;
    logic [ADDR_W-1:0]   pend_addr_reg;
    logic                read_hit_reg;
    tcw_pkg::cell_t      rd_data_reg;
    logic                out_valid_reg;
    tcw_pkg::out_item_t  out_data_reg;
    tcw_pkg::out_item_t  out_data_next;

    logic                is_nl;
    logic                is_cr;
    logic                is_bs;
    logic                printable;
    logic                on_last_row;
    logic                overflow;
    logic [ADDR_W-1:0]   line_start;
    logic                idx_hit;
    logic [ADDR_W+10:0]  idx_wide;
    logic [ADDR_W-1:0]   idx_addr;
    logic [ADDR_W+10:0]  lin_wide;
    logic                sweep_copying;

    logic                exec_we;
    logic [ADDR_W-1:0]   exec_waddr;
    tcw_pkg::cell_t      exec_wdata;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    tcw_pkg::cell_t      mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= tcw_pkg::RESET_COLOR;
        end
        else if (cfg_we)
        begin
            text_color_reg <= cfg_wdata;
        end
    end

    // held input beat
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_data;
        end
    end

    // decode of the held beat
    assign is_nl       = item_reg.char_code == tcw_pkg::CH_NEWLINE;
    assign is_cr       = item_reg.char_code == tcw_pkg::CH_RETURN;
    assign is_bs       = item_reg.char_code == tcw_pkg::CH_BACKSPACE;
    assign printable   = !(is_nl || is_cr || is_bs);
    assign on_last_row = row_reg == LAST_ROW;
    assign line_start  = lin_reg - ADDR_W'(col_reg);
    assign overflow    = (item_reg.opcode == tcw_pkg::OP_PUT) && on_last_row
                         && (is_nl || (printable && (col_reg == LAST_COL)));
    assign idx_hit     = {21'b0, item_reg.cell_index} < 32'(CELLS);
    assign idx_wide    = {ADDR_W'(0), item_reg.cell_index};
    assign idx_addr    = idx_wide[ADDR_W-1:0];

    assign status.need_sweep = overflow || (item_reg.opcode == tcw_pkg::OP_CLEAR);
    assign status.sweep_last = sweep_cnt_reg == LAST_ADDR;
    assign status.out_free   = !out_valid_reg || out_ready;

    // cursor movement and single cell write of one item
    always_comb
    begin
        row_next         = row_reg;
        col_next         = col_reg;
        lin_next         = lin_reg;
        exec_we          = 1'b0;
        exec_waddr       = lin_reg;
        exec_wdata.color = text_color_reg;
        exec_wdata.ch    = item_reg.char_code;
        unique case (item_reg.opcode)
            tcw_pkg::OP_PUT:
            begin
                priority if (is_nl)
                begin
                    col_next = '0;
                    if (on_last_row)
                    begin
                        lin_next = LAST_BASE;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                        lin_next = line_start + ROW_STEP;
                    end
                end
                else if (is_cr)
                begin
                    col_next = '0;
                    lin_next = line_start;
                end
                else if (is_bs)
                begin
                    if (col_reg != '0)
                    begin
                        col_next      = col_reg - 1'b1;
                        lin_next      = lin_reg - 1'b1;
                        exec_we       = 1'b1;
                        exec_waddr    = lin_reg - 1'b1;
                        exec_wdata.ch = tcw_pkg::BLANK_CHAR;
                    end
                end
                else
                begin
                    exec_we = 1'b1;
                    if (col_reg == LAST_COL)
                    begin
                        col_next = '0;
                        if (on_last_row)
                        begin
                            lin_next = LAST_BASE;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                            lin_next = lin_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                        lin_next = lin_reg + 1'b1;
                    end
                end
            end
            tcw_pkg::OP_CLEAR:
            begin
                row_next = '0;
                col_next = '0;
                lin_next = '0;
            end
            default:
            begin
                exec_we = 1'b0;
            end
        endcase
    end

    // cursor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            lin_reg <= '0;
        end
        else if (cmd.exec)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            lin_reg <= lin_next;
        end
    end

    // sweep counter: scroll copies rows up, clear and reset blank every cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg   <= '0;
            sweep_copy_reg  <= 1'b0;
            sweep_color_reg <= tcw_pkg::RESET_COLOR;
        end
        else if (cmd.exec)
        begin
            sweep_cnt_reg   <= '0;
            sweep_copy_reg  <= overflow;
            sweep_color_reg <= text_color_reg;
        end
        else if (cmd.sweep_step)
        begin
            sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
        end
    end

    assign sweep_copying = sweep_copy_reg && (sweep_cnt_reg < COPY_END);

    // write stage of the sweep, in the cycle after the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= cmd.sweep_step;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= sweep_cnt_reg;
        pend_copy_reg <= sweep_copying;
    end

    // memory port selection
    always_comb
    begin
        mem_we = pend_valid_reg || (cmd.exec && exec_we);
        if (pend_valid_reg)
        begin
            mem_waddr = pend_addr_reg;
            if (pend_copy_reg)
            begin
                mem_wdata = rd_data_reg;
            end
            else
            begin
                mem_wdata.color = sweep_color_reg;
                mem_wdata.ch    = tcw_pkg::BLANK_CHAR;
            end
        end
        else
        begin
            mem_waddr = exec_waddr;
            mem_wdata = exec_wdata;
        end
        mem_re    = (cmd.sweep_step && sweep_copying)
                    || (cmd.exec && (item_reg.opcode == tcw_pkg::OP_READ) && idx_hit);
        mem_raddr = cmd.sweep_step ? (sweep_cnt_reg + ROW_STEP) : idx_addr;
    end

    // screen store, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // read hit flag for the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_hit_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            read_hit_reg <= (item_reg.opcode == tcw_pkg::OP_READ) && idx_hit;
        end
    end

    // result beat
    assign lin_wide = {11'b0, lin_reg};

    always_comb
    begin
        out_data_next.cursor_position = lin_wide[10:0];
        out_data_next.cell_char       = read_hit_reg ? rd_data_reg.ch : 8'd0;
        out_data_next.cell_color      = read_hit_reg ? rd_data_reg.color : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hw/rtl/text_console_writer_core.sv @@
// Text console writer: a screen store of ROWS x COLUMNS cells (character and
// attribute) with a cursor. Input beats on in_valid/in_ready carry an opcode
// (put byte, clear screen, read cell), a byte and a cell index. Each input
// beat gives exactly one output beat on out_valid/out_ready with the linear
// cursor position and, for a read, the cell's character and attribute.
// cfg_we/cfg_wdata write the attribute byte used for written and blanked
// cells; write it only while the block is idle.
// A plain put, read or unused opcode goes from idle through the execute
// and result states before its result is loaded; a new beat is taken only
// after that, while the output register drains.
// A scroll (put past the last row) or a clear adds a sweep over all ROWS*COLUMNS
// cells: it walks the store one cell a cycle through its single write port.
// After reset the store is blanked in attribute 0x1F while in_ready is held
// low; configuration writes are taken meanwhile.
// The output register holds a finished result while out_ready is low; the
// next input beat is taken, but its result waits until the register frees.
module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tcw_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output tcw_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata
);

    tcw_pkg::dp_cmd_t    cmd;
    tcw_pkg::dp_status_t status;

    // sequencer
    tcw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // screen store, cursor and result register
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

`ifndef ASSERT_OFF
    // one beat at a time: taking a beat closes the input side
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in work");

    // a result is loaded only from the result state, never from idle
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without an item in work");

    // reported cursor stays on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({21'b0, out_data.cursor_position} < 32'(ROWS * COLUMNS)))
        else $error("cursor position beyond the screen");
`endif

endmodule

@@ verif/text_console_writer_core_tb.sv @@
`timescale 1ns / 100ps

module text_console_writer_core_tb;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELL_COUNT   = COLUMNS * ROWS;
    localparam int PHASE_ITEMS  = 325;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 20_000_000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum int
    {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE
    } ready_mode_t;

    // shadow of the screen store and cursor, with the reports still owed
    class console_shadow;
        tcw_pkg::cell_t     screen [CELL_COUNT];
        logic [4:0]         row;
        logic [6:0]         col;
        logic [7:0]         text_color;
        tcw_pkg::out_item_t awaited_reports [$];
        int                 errors;

        function new();
            text_color = tcw_pkg::RESET_COLOR;
            blank_screen();
            row    = '0;
            col    = '0;
            errors = 0;
        endfunction

        function void set_color(logic [7:0] value);
            text_color = value;
        endfunction

        function int cursor_cell();
            return int'(row) * COLUMNS + int'(col);
        endfunction

        function void blank_screen();
            foreach (screen[i])
                screen[i] = {text_color, tcw_pkg::BLANK_CHAR};
        endfunction

        // rows move up one, bottom row blanked in the current colour
        function void scroll_up();
            for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                screen[i] = screen[i + COLUMNS];
            for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                screen[i] = {text_color, tcw_pkg::BLANK_CHAR};
        endfunction

        function void put_byte(logic [7:0] b);
            case (b)
                tcw_pkg::CH_NEWLINE:
                begin
                    col = '0;
                    row = row + 5'd1;
                end
                tcw_pkg::CH_RETURN:
                begin
                    col = '0;
                end
                tcw_pkg::CH_BACKSPACE:
                begin
                    if (col != 0)
                    begin
                        col = col - 7'd1;
                        screen[cursor_cell()] = {text_color, tcw_pkg::BLANK_CHAR};
                    end
                end
                default:
                begin
                    screen[cursor_cell()] = {text_color, b};
                    col = col + 7'd1;
                    if (int'(col) >= COLUMNS)
                    begin
                        col = '0;
                        row = row + 5'd1;
                    end
                end
            endcase
            if (int'(row) >= ROWS)
            begin
                scroll_up();
                row = 5'(ROWS - 1);
            end
        endfunction

        // accepted input beat: update the shadow and queue the report it owes
        function void note_command(tcw_pkg::in_item_t c);
            tcw_pkg::out_item_t r;
            r = '0;
            case (c.opcode)
                tcw_pkg::OP_PUT:
                begin
                    put_byte(c.char_code);
                end
                tcw_pkg::OP_CLEAR:
                begin
                    blank_screen();
                    row = '0;
                    col = '0;
                end
                tcw_pkg::OP_READ:
                begin
                    if (int'(c.cell_index) < CELL_COUNT)
                    begin
                        r.cell_char  = screen[c.cell_index].ch;
                        r.cell_color = screen[c.cell_index].color;
                    end
                end
                default:
                begin
                end
            endcase
            r.cursor_position = 11'(cursor_cell());
            awaited_reports.push_back(r);
        endfunction

        // accepted output beat against the oldest owed report
        function void check_result(tcw_pkg::out_item_t got);
            tcw_pkg::out_item_t want;
            if (awaited_reports.size() == 0)
            begin
                $display("%0t: report with none owed, expected nothing, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = awaited_reports.pop_front();
            if (got.cursor_position !== want.cursor_position)
            begin
                $display("%0t: cursor_position expected %0d actual %0d",
                         $time, want.cursor_position, got.cursor_position);
                errors++;
            end
            if (got.cell_char !== want.cell_char)
            begin
                $display("%0t: cell_char expected %h actual %h",
                         $time, want.cell_char, got.cell_char);
                errors++;
            end
            if (got.cell_color !== want.cell_color)
            begin
                $display("%0t: cell_color expected %h actual %h",
                         $time, want.cell_color, got.cell_color);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    tcw_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    tcw_pkg::out_item_t out_data;
    logic               cfg_we;
    logic [7:0]         cfg_wdata;

    console_shadow shadow;
    int            reports_seen;
    int            chars_to_line_end;

    text_console_writer_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // cycle limit
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // output beat monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            shadow.check_result(out_data);
            reports_seen++;
        end
    end

    // receiver: stretches of differing readiness, plus one long hold-off
    initial
    begin : receiver
        ready_mode_t mode;
        int          stretch;
        bit          held;
        out_ready = 1'b0;
        held      = 1'b0;
        forever
        begin
            mode    = ready_mode_t'($urandom_range(0, 2));
            stretch = $urandom_range(20, 200);
            repeat (stretch)
            begin
                @(negedge clk);
                case (mode)
                    READY_ALWAYS: out_ready <= 1'b1;
                    READY_RANDOM: out_ready <= 1'($urandom_range(0, 1));
                    default:      out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
            if (!held && reports_seen >= 500 && in_valid)
            begin
                held = 1'b1;
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
        end
    end

    function automatic tcw_pkg::in_item_t make_command(logic [1:0] op, logic [7:0] b,
                                                       logic [10:0] idx);
        tcw_pkg::in_item_t c;
        c.opcode     = op;
        c.char_code  = b;
        c.cell_index = idx;
        return c;
    endfunction

    // mostly lines of text with random bytes, some reads, backspaces and noise
    function automatic tcw_pkg::in_item_t next_random_command();
        tcw_pkg::in_item_t c;
        int                pick;
        int                shape;
        pick         = $urandom_range(0, 399);
        c.opcode     = tcw_pkg::OP_PUT;
        c.char_code  = 8'($urandom);
        c.cell_index = 11'($urandom);
        if (pick < 36)
            c.opcode = tcw_pkg::OP_READ;
        else if (pick < 40)
            c.opcode = OP_UNUSED;
        else if (pick < 41)
            c.opcode = tcw_pkg::OP_CLEAR;
        else if (pick < 56)
            c.char_code = tcw_pkg::CH_BACKSPACE;
        else if (chars_to_line_end == 0)
        begin
            c.char_code = ($urandom_range(0, 3) == 0) ? tcw_pkg::CH_RETURN
                                                      : tcw_pkg::CH_NEWLINE;
            shape = $urandom_range(0, 9);
            if (shape < 7)
                chars_to_line_end = $urandom_range(0, 30);
            else if (shape < 9)
                chars_to_line_end = $urandom_range(31, 79);
            else
                chars_to_line_end = $urandom_range(80, 170);
        end
        else
            chars_to_line_end--;
        return c;
    endfunction

    task automatic send_beat(input tcw_pkg::in_item_t c);
        in_valid <= 1'b1;
        in_data  <= c;
        do
            @(posedge clk);
        while (!in_ready);
        shadow.note_command(c);
        @(negedge clk);
    endtask

    // bursts of beats with random gaps between them
    task automatic offer_commands(input tcw_pkg::in_item_t cmds [$]);
        int burst;
        int gap;
        while (cmds.size() > 0)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && cmds.size() > 0)
            begin
                send_beat(cmds.pop_front());
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (shadow.awaited_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_text_color(input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        shadow.set_color(value);
    endtask

    // main sequence
    initial
    begin : stimulus
        tcw_pkg::in_item_t directed_cmds [$];
        tcw_pkg::in_item_t random_cmds [$];
        logic [7:0]        phase_colors [6];
        shadow            = new();
        reports_seen      = 0;
        chars_to_line_end = 0;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        in_data           = '0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed beats at the reset colour
        directed_cmds.push_back(make_command(tcw_pkg::OP_READ, 8'h00, 11'd0));
        directed_cmds.push_back(make_command(tcw_pkg::OP_READ, 8'h00, 11'd1999));
        directed_cmds.push_back(make_command(tcw_pkg::OP_READ, 8'h00, 11'd2000));
        directed_cmds.push_back(make_command(tcw_pkg::OP_READ, 8'hFF, 11'h7FF));
        directed_cmds.push_back(make_command(OP_UNUSED, 8'hFF, 11'h7FF));
        directed_cmds.push_back(make_command(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 11'd0));
        directed_cmds.push_back(make_command(tcw_pkg::OP_PUT, 8'h00, 11'h7FF));
        directed_cmds.push_back(make_command(tcw_pkg::OP_PUT, 8'hFF, 11'd0));
        directed_cmds.push_back(make_command(tcw_pkg::OP_PUT, 8'h41, 11'd0));
        directed_cmds.push_back(make_command(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 11'd0));
        directed_cmds.push_back(make_command(tcw_pkg::OP_READ, 8'h00, 11'd2));
        directed_cmds.push_back(make_command(tcw_pkg::OP_READ, 8'h00, 11'd1));
        directed_cmds.push_back(make_command(tcw_pkg::OP_READ, 8'h00, 11'd0));
        directed_cmds.push_back(make_command(tcw_pkg::OP_PUT, tcw_pkg::CH_RETURN, 11'd0));
        directed_cmds.push_back(make_command(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 11'd0));
        directed_cmds.push_back(make_command(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 11'd0));
        directed_cmds.push_back(make_command(tcw_pkg::OP_PUT, 8'h5A, 11'd0));
        directed_cmds.push_back(make_command(tcw_pkg::OP_READ, 8'h00, 11'd160));
        directed_cmds.push_back(make_command(tcw_pkg::OP_CLEAR, 8'hFF, 11'h7FF));
        directed_cmds.push_back(make_command(tcw_pkg::OP_READ, 8'h00, 11'd0));
        directed_cmds.push_back(make_command(tcw_pkg::OP_READ, 8'h00, 11'd160));
        offer_commands(directed_cmds);
        wait_drained();

        // random phases, each under its own colour
        phase_colors[0] = 8'h00;
        phase_colors[1] = 8'hFF;
        phase_colors[2] = 8'($urandom);
        phase_colors[3] = tcw_pkg::RESET_COLOR;
        phase_colors[4] = 8'($urandom);
        phase_colors[5] = 8'($urandom);
        foreach (phase_colors[p])
        begin
            write_text_color(phase_colors[p]);
            random_cmds.delete();
            repeat (PHASE_ITEMS)
                random_cmds.push_back(next_random_command());
            offer_commands(random_cmds);
            wait_drained();
        end

        repeat (16) @(posedge clk);
        if (shadow.errors == 0 && shadow.awaited_reports.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
